[sv/rar_pkg.sv]
// shared constants for the rational arithmetic reduce unit
`timescale 1ns / 1ps
`default_nettype none

package rar_pkg;

   localparam int OPERAND_BITS_DEF = 16;
   localparam int FUNC_W           = 3;
   localparam int RES_NUM_W        = 32;
   localparam int RES_DEN_W        = 31;

   localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SUB     = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_MUL     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DIV     = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_LESS    = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_GREATER = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_EQUAL   = 3'd6;

endpackage

`default_nettype wire

[sv/rational_arith_reduce_unit.sv]
// compares and the unused code give the result from S_NSUM, with no gcd or division
// arithmetic ops go on through S_MAG, the gcd and both divisions, W = 2*OPERAND_BITS
// the time goes to the binary gcd and two W-step divisions on one divider
// one item at a time: busy stays high from the accepting edge until the result strobe
// rsp_valid is high one cycle per item and cannot be held off by the receiver
// synchronous active-high reset returns the sequencer to idle with no strobe pending
`timescale 1ns / 1ps
`default_nettype none

module rational_arith_reduce_unit #(
   parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [rar_pkg::FUNC_W-1:0]           req_func,
   input  wire logic signed [OPERAND_BITS-1:0]       req_a_num,
   input  wire logic [OPERAND_BITS-2:0]              req_a_den,
   input  wire logic signed [OPERAND_BITS-1:0]       req_b_num,
   input  wire logic [OPERAND_BITS-2:0]              req_b_den,
   output logic                                      rsp_valid,
   output logic signed [rar_pkg::RES_NUM_W-1:0]      rsp_res_num,
   output logic [rar_pkg::RES_DEN_W-1:0]             rsp_res_den,
   output logic                                      rsp_cmp_true
);
   import rar_pkg::*;

   localparam int OB = OPERAND_BITS;
   localparam int DW = OB - 1;
   localparam int W  = 2 * OB;
   localparam int XW = (W > RES_NUM_W) ? W : RES_NUM_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_NSUM,
      S_MAG,
      S_GCD,
      S_DIVN,
      S_DIVD
   } state_type;

   state_type                 state_ff;
   logic [2:0]                mul_cnt_ff;
   logic [FUNC_W-1:0]         func_ff;
   logic signed [OB-1:0]      an_ff;
   logic signed [OB-1:0]      bn_ff;
   logic [DW-1:0]             ad_ff;
   logic [DW-1:0]             bd_ff;
   logic signed [W-1:0]       p_ff;
   logic signed [W-1:0]       q_ff;
   logic signed [W-1:0]       nprod_ff;
   logic signed [W-1:0]       dprod_ff;
   logic signed [W-1:0]       n_ff;
   logic signed [W-1:0]       d_ff;
   logic                      neg_ff;
   logic [W-1:0]              n_mag_ff;
   logic [W-1:0]              d_mag_ff;
   logic [W-1:0]              g_ff;
   logic [W-1:0]              qn_ff;
   logic                      gcd_start_ff;
   logic                      div_start_ff;
   logic                      rsp_valid_ff;
   logic signed [RES_NUM_W-1:0] rsp_res_num_ff;
   logic [RES_DEN_W-1:0]      rsp_res_den_ff;
   logic                      rsp_cmp_true_ff;

   logic signed [OB:0]        mul_a;
   logic signed [OB:0]        mul_b;
   logic signed [W-1:0]       prod;
   logic                      gcd_done;
   logic [W-1:0]              gcd_val;
   logic                      div_done;
   logic [W-1:0]              div_quo;
   logic [W-1:0]              div_dividend;
   logic signed [OB:0]        an_x;
   logic signed [OB:0]        bn_x;
   logic signed [OB:0]        ad_x;
   logic signed [OB:0]        bd_x;
   logic [XW-1:0]             qn_ext;
   logic [XW-1:0]             num_ext;
   logic [XW-1:0]             den_ext;

   assign an_x = {an_ff[OB-1], an_ff};
   assign bn_x = {bn_ff[OB-1], bn_ff};
   assign ad_x = {2'b00, ad_ff};
   assign bd_x = {2'b00, bd_ff};

   // cross products in order: a*bd, b*ad, a*b, then the result denominator
   always_comb begin
      mul_a = an_x;
      mul_b = bd_x;
      unique case (mul_cnt_ff)
         3'd0: begin
            mul_a = an_x;
            mul_b = bd_x;
         end
         3'd1: begin
            mul_a = bn_x;
            mul_b = ad_x;
         end
         3'd2: begin
            mul_a = an_x;
            mul_b = bn_x;
         end
         3'd3: begin
            mul_a = ad_x;
            mul_b = (func_ff == FUNC_DIV) ? bn_x : bd_x;
         end
         default: begin
            mul_a = an_x;
            mul_b = bd_x;
         end
      endcase
   end

   rar_mul #(.OB(OB)) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   rar_gcd #(.W(W)) u_gcd (
      .clock   (clock),
      .reset   (reset),
      .start   (gcd_start_ff),
      .x       (n_mag_ff),
      .y       (d_mag_ff),
      .done_ff (gcd_done),
      .gcd_ff  (gcd_val)
   );

   assign div_dividend = (state_ff == S_DIVD) ? d_mag_ff : n_mag_ff;

   rar_div #(.W(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend),
      .divisor  (g_ff),
      .done_ff  (div_done),
      .quo_ff   (div_quo)
   );

   assign qn_ext  = XW'(qn_ff);
   assign num_ext = neg_ff ? (XW'(0) - qn_ext) : qn_ext;
   assign den_ext = XW'(div_quo);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mul_cnt_ff   <= '0;
         gcd_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gcd_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  func_ff    <= req_func;
                  an_ff      <= req_a_num;
                  bn_ff      <= req_b_num;
                  // a zero denominator reads as one
                  ad_ff      <= (req_a_den == '0) ? DW'(1) : req_a_den;
                  bd_ff      <= (req_b_den == '0) ? DW'(1) : req_b_den;
                  mul_cnt_ff <= '0;
                  state_ff   <= S_MUL;
               end
            end
            S_MUL: begin
               // product of step k is registered in the multiplier and read at step k+1
               mul_cnt_ff <= mul_cnt_ff + 3'd1;
               unique case (mul_cnt_ff)
                  3'd1:    p_ff     <= prod;
                  3'd2:    q_ff     <= prod;
                  3'd3:    nprod_ff <= prod;
                  3'd4: begin
                     dprod_ff <= prod;
                     state_ff <= S_NSUM;
                  end
                  default: ;
               endcase
            end
            S_NSUM: begin
               d_ff     <= (dprod_ff == '0) ? W'(1) : dprod_ff;
               unique case (func_ff)
                  FUNC_ADD: begin
                     n_ff     <= p_ff + q_ff;
                     state_ff <= S_MAG;
                  end
                  FUNC_SUB: begin
                     n_ff     <= p_ff - q_ff;
                     state_ff <= S_MAG;
                  end
                  FUNC_MUL: begin
                     n_ff     <= nprod_ff;
                     state_ff <= S_MAG;
                  end
                  FUNC_DIV: begin
                     n_ff     <= p_ff;
                     state_ff <= S_MAG;
                  end
                  FUNC_LESS, FUNC_GREATER, FUNC_EQUAL: begin
                     rsp_res_num_ff  <= '0;
                     rsp_res_den_ff  <= '0;
                     rsp_cmp_true_ff <= (func_ff == FUNC_LESS)    ? (p_ff < q_ff) :
                                        (func_ff == FUNC_GREATER) ? (p_ff > q_ff) :
                                                                    (p_ff == q_ff);
                     rsp_valid_ff    <= 1'b1;
                     state_ff        <= S_IDLE;
                  end
                  default: begin
                     rsp_res_num_ff  <= '0;
                     rsp_res_den_ff  <= '0;
                     rsp_cmp_true_ff <= 1'b0;
                     rsp_valid_ff    <= 1'b1;
                     state_ff        <= S_IDLE;
                  end
               endcase
            end
            S_MAG: begin
               neg_ff       <= n_ff[W-1] ^ d_ff[W-1];
               n_mag_ff     <= n_ff[W-1] ? W'(-n_ff) : W'(n_ff);
               d_mag_ff     <= d_ff[W-1] ? W'(-d_ff) : W'(d_ff);
               gcd_start_ff <= 1'b1;
               state_ff     <= S_GCD;
            end
            S_GCD: begin
               if (gcd_done) begin
                  g_ff         <= gcd_val;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIVN;
               end
            end
            S_DIVN: begin
               if (div_done) begin
                  qn_ff        <= div_quo;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIVD;
               end
            end
            S_DIVD: begin
               if (div_done) begin
                  rsp_res_num_ff  <= num_ext[RES_NUM_W-1:0];
                  rsp_res_den_ff  <= den_ext[RES_DEN_W-1:0];
                  rsp_cmp_true_ff <= 1'b0;
                  rsp_valid_ff    <= 1'b1;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_num  = rsp_res_num_ff;
   assign rsp_res_den  = rsp_res_den_ff;
   assign rsp_cmp_true = rsp_cmp_true_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmp_true |-> rsp_res_num == '0 && rsp_res_den == '0)
      else $error("compare result carries a fraction");

   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      gcd_done |-> gcd_val != '0)
      else $error("gcd of nonzero denominator came out zero");

   a_div_phase: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVN || state_ff == S_DIVD)
      else $error("divider finished outside a division phase");

endmodule

`default_nettype wire

[sv/rar_mul.sv]
// registered signed multiplier shared by all cross products
`timescale 1ns / 1ps
`default_nettype none

module rar_mul #(
   parameter int OB = rar_pkg::OPERAND_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic signed [OB:0]    op_a,
   input  wire logic signed [OB:0]    op_b,
   output logic signed [2*OB-1:0]     prod_ff
);
   import rar_pkg::*;

   logic signed [2*OB+1:0] prod_in;

   assign prod_in = op_a * op_b;

   // operands never exceed 2*OB bits of product magnitude
   always_ff @(posedge clock) begin
      prod_ff <= prod_in[2*OB-1:0];
   end

endmodule

`default_nettype wire

[sv/rar_gcd.sv]
// binary gcd unit, one shift or subtract step per cycle
`timescale 1ns / 1ps
`default_nettype none

module rar_gcd #(
   parameter int W = 2 * rar_pkg::OPERAND_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [W-1:0]  x,
   input  wire logic [W-1:0]  y,
   output logic               done_ff,
   output logic [W-1:0]       gcd_ff
);
   import rar_pkg::*;

   localparam int KW = $clog2(W) + 1;

   typedef enum logic {
      G_IDLE,
      G_RUN
   } state_type;

   state_type       state_ff;
   logic [W-1:0]    u_ff;
   logic [W-1:0]    v_ff;
   logic [KW-1:0]   k_ff;
   logic            u_ge_v;
   logic [W-1:0]    u_minus_v;
   logic [W-1:0]    v_minus_u;

   assign u_ge_v    = (u_ff >= v_ff);
   assign u_minus_v = u_ff - v_ff;
   assign v_minus_u = v_ff - u_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            G_IDLE: begin
               if (start) begin
                  u_ff     <= x;
                  v_ff     <= y;
                  k_ff     <= '0;
                  state_ff <= G_RUN;
               end
            end
            G_RUN: begin
               priority if (u_ff == '0 || v_ff == '0) begin
                  // put back the common powers of two
                  gcd_ff   <= (u_ff | v_ff) << k_ff;
                  done_ff  <= 1'b1;
                  state_ff <= G_IDLE;
               end else if (!u_ff[0] && !v_ff[0]) begin
                  u_ff <= u_ff >> 1;
                  v_ff <= v_ff >> 1;
                  k_ff <= k_ff + KW'(1);
               end else if (!u_ff[0]) begin
                  u_ff <= u_ff >> 1;
               end else if (!v_ff[0]) begin
                  v_ff <= v_ff >> 1;
               end else if (u_ge_v) begin
                  // difference of two odd values is even
                  u_ff <= u_minus_v >> 1;
               end else begin
                  v_ff <= v_minus_u >> 1;
               end
            end
            default: state_ff <= G_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

[sv/rar_div.sv]
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module rar_div #(
   parameter int W = 2 * rar_pkg::OPERAND_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [W-1:0]  dividend,
   input  wire logic [W-1:0]  divisor,
   output logic               done_ff,
   output logic [W-1:0]       quo_ff
);
   import rar_pkg::*;

   localparam int CW = $clog2(W + 1);

   logic            run_ff;
   logic [CW-1:0]   cnt_ff;
   logic [W-1:0]    rem_ff;
   logic [W-1:0]    dsor_ff;
   logic [W:0]      rem_shift;
   logic            fits;
   logic [W:0]      rem_sub;

   assign rem_shift = {rem_ff, quo_ff[W-1]};
   assign fits      = (rem_shift >= {1'b0, dsor_ff});
   assign rem_sub   = rem_shift - {1'b0, dsor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dsor_ff <= divisor;
         end else if (run_ff) begin
            rem_ff <= fits ? rem_sub[W-1:0] : rem_shift[W-1:0];
            quo_ff <= {quo_ff[W-2:0], fits};
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire
